@@ hw/rtl/lsb_first_code_symbol_packer_macros.svh @@
// Assertion macros shared by the packer RTL.
`ifndef LSB_FIRST_CODE_SYMBOL_PACKER_MACROS_SVH
`define LSB_FIRST_CODE_SYMBOL_PACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCSP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCSP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Invariant on every cycle out of reset.
`define LCSP_ASSERT_INV(label, clk, rstn, cond, msg) \
    `LCSP_ASSERT_IMP(label, clk, rstn, 1'b1, cond, msg)

`endif

@@ hw/rtl/lcsp_pkg.sv @@
// Types and constants shared by the code/symbol packer modules.
package lcsp_pkg;

    localparam int CODE_BITS   = 16;
    localparam int LEN_BITS    = 5;
    localparam int SYM_BITS    = 8;
    localparam int S_DATA_BITS = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;
    localparam int LEFT_BITS   = 5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    typedef enum logic {
        KIND_PAIR  = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CODE_BITS-1:0]  code;
        logic [LEN_BITS-1:0]   len;
        logic [SYM_BITS-1:0]   symbol;
    } cmd_t;

endpackage

@@ hw/rtl/lcsp_queue.sv @@
// Short command queue between the front and back parts.
`include "lsb_first_code_symbol_packer_macros.svh"

module lcsp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lcsp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output lcsp_pkg::cmd_t q_cmd
);
    import lcsp_pkg::*;

    cmd_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == QCNT_BITS'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `LCSP_ASSERT_INV(a_q_count_range, aclk, aresetn, count_reg <= QCNT_BITS'(QDEPTH), "queue count over depth")
    `LCSP_ASSERT_IMP(a_q_no_underflow, aclk, aresetn, pop, q_valid, "pop from empty queue")

endmodule

@@ hw/rtl/lcsp_front.sv @@
// Front part: accepts input words, clamps the code length and masks the code.
module lcsp_front #(
    parameter int CODE_WIDTH = 16
) (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcsp_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_full,
    output logic                                push,
    output lcsp_pkg::cmd_t                      push_cmd
);
    import lcsp_pkg::*;

    localparam int LEN_MAX = (CODE_WIDTH < CODE_BITS) ? CODE_WIDTH : CODE_BITS;

    logic [CODE_BITS-1:0] in_code;
    logic [LEN_BITS-1:0]  in_len;
    logic [SYM_BITS-1:0]  in_sym;
    logic [LEN_BITS-1:0]  len_sat;
    logic [CODE_BITS-1:0] code_mask;

    assign in_code = s_tdata[CODE_BITS-1:0];
    assign in_len  = s_tdata[CODE_BITS +: LEN_BITS];
    assign in_sym  = s_tdata[CODE_BITS+LEN_BITS +: SYM_BITS];

    assign len_sat   = (in_len > LEN_BITS'(LEN_MAX)) ? LEN_BITS'(LEN_MAX) : in_len;
    assign code_mask = ~({CODE_BITS{1'b1}} << len_sat);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        push_cmd.kind   = kind_t'(s_tuser);
        push_cmd.code   = in_code & code_mask;
        push_cmd.len    = len_sat;
        push_cmd.symbol = in_sym;
    end

endmodule

@@ hw/rtl/lcsp_back.sv @@
// Back part: packs bits or spells characters, one output word per cycle while m_tready does not stall it.
`include "lsb_first_code_symbol_packer_macros.svh"

module lcsp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ascii_mode,
    input  logic           q_valid,
    input  lcsp_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import lcsp_pkg::*;

    // pending partial byte
    logic [7:0]            pend_bits_reg, pend_bits_next;
    logic [2:0]            pend_cnt_reg, pend_cnt_next;

    // current operation
    logic                  busy_reg, busy_next;
    logic                  asc_reg, asc_next;
    logic [LEFT_BITS-1:0]  left_reg, left_next;
    logic [23:0]           word_reg, word_next;
    logic [LEFT_BITS-1:0]  idx_reg, idx_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;
    logic [SYM_BITS-1:0]   sym_reg, sym_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  emit_ok, fire, done, pop;
    logic [7:0]            cur_byte;
    logic [7:0]            asc_char;
    logic [LEN_BITS-1:0]   sh;
    logic [LEN_BITS-1:0]   total;
    logic [30:0]           combined;
    logic [7:0]            rest;

    assign emit_ok = !m_valid_reg || m_tready;
    assign fire    = busy_reg && emit_ok;
    assign done    = fire && (left_reg == LEFT_BITS'(1));
    assign pop     = q_valid && (!busy_reg || done);
    assign q_pop   = pop;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ASCII character at position idx: space, code bits, space, symbol bits
    always_comb begin
        logic [LEFT_BITS-1:0] ci;
        logic [LEFT_BITS-1:0] si;
        ci = idx_reg - LEFT_BITS'(1);
        si = idx_reg - len_reg - LEFT_BITS'(2);
        if (idx_reg == '0) begin
            asc_char = CHAR_SPACE;
        end else if (idx_reg <= len_reg) begin
            asc_char = code_reg[ci[3:0]] ? CHAR_ONE : CHAR_ZERO;
        end else if (idx_reg == len_reg + LEFT_BITS'(1)) begin
            asc_char = CHAR_SPACE;
        end else begin
            asc_char = sym_reg[si[2:0]] ? CHAR_ONE : CHAR_ZERO;
        end
    end

    assign cur_byte = asc_reg ? asc_char : word_reg[7:0];

    // packed append of the queued pair onto the pending byte
    assign sh       = LEN_BITS'(pend_cnt_reg) + q_cmd.len;
    assign total    = sh + LEN_BITS'(8);
    assign combined = {23'd0, pend_bits_reg}
                    | ({15'd0, q_cmd.code} << pend_cnt_reg)
                    | ({23'd0, q_cmd.symbol} << sh);

    always_comb begin
        case (total[4:3])
            2'd1:    rest = combined[15:8];
            2'd2:    rest = combined[23:16];
            2'd3:    rest = {1'b0, combined[30:24]};
            default: rest = combined[7:0];
        endcase
    end

    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        busy_next      = busy_reg;
        asc_next       = asc_reg;
        left_next      = left_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        code_next      = code_reg;
        sym_next       = sym_reg;

        if (fire) begin
            left_next = left_reg - LEFT_BITS'(1);
            idx_next  = idx_reg + LEFT_BITS'(1);
            word_next = {8'd0, word_reg[23:8]};
            if (done) begin
                busy_next = 1'b0;
            end
        end

        if (pop) begin
            idx_next  = '0;
            len_next  = q_cmd.len;
            code_next = q_cmd.code;
            sym_next  = q_cmd.symbol;
            asc_next  = ascii_mode;
            case (q_cmd.kind)
                KIND_PAIR: begin
                    busy_next = 1'b1;
                    if (ascii_mode) begin
                        left_next = q_cmd.len + LEFT_BITS'(10);
                    end else begin
                        left_next      = LEFT_BITS'(total[4:3]);
                        word_next      = combined[23:0];
                        pend_bits_next = rest;
                        pend_cnt_next  = total[2:0];
                    end
                end
                KIND_FLUSH: begin
                    if (!ascii_mode && pend_cnt_reg != '0) begin
                        busy_next      = 1'b1;
                        left_next      = LEFT_BITS'(1);
                        word_next      = {16'd0, pend_bits_reg};
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end else begin
                        busy_next = 1'b0;
                        left_next = '0;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                    left_next = '0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_byte;
            m_last_next  = (left_reg == LEFT_BITS'(1));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        asc_reg    <= asc_next;
        word_reg   <= word_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        code_reg   <= code_next;
        sym_reg    <= sym_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    `LCSP_ASSERT_INV(a_pend_clean, aclk, aresetn, (pend_bits_reg >> pend_cnt_reg) == 8'd0, "pending bits above count")
    `LCSP_ASSERT_IMP(a_busy_left, aclk, aresetn, busy_reg, left_reg != '0, "busy with nothing left")
    `LCSP_ASSERT_IMP(a_pop_on_last, aclk, aresetn, pop && busy_reg, done, "pop before last word")
    `LCSP_ASSERT_NXT(a_fire_shows, aclk, aresetn, fire, m_valid_reg, "emitted word not held")

endmodule

@@ hw/rtl/lsb_first_code_symbol_packer.sv @@
// Top level of the LSB-first code/symbol packer.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    tdata: code, code_len, symbol; tuser: kind
//  m_       out  m_tvalid / m_tready    tdata: out_byte; tlast: last
//  cfg_     in   cfg_valid / cfg_ready  data: ascii_mode
//
// The back part emits one output word per cycle through its output register, unless m_tready stalls it.
// Packed pair: 1 to 3 words (one per byte completed); flush: one word if bits are pending.
// ASCII pair: code_len + 10 words, one character each.
// A 4-entry queue lets the input side keep accepting while the output stalls, until it fills.
// Reset clears the pending byte, the queue and ascii_mode; no clearing pass.
`include "lsb_first_code_symbol_packer_macros.svh"

module lsb_first_code_symbol_packer #(
    parameter int CODE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lcsp_pkg::S_DATA_BITS-1:0] s_tdata,   // code[15:0] code_len[20:16] symbol[28:21]
    input  logic                             s_tuser,   // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // out_byte[7:0]
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data
);
    import lcsp_pkg::*;

    logic ascii_mode_reg, ascii_mode_next;
    logic q_full, push, pop, q_valid;
    cmd_t push_cmd, q_cmd;

    assign cfg_ready       = 1'b1;
    assign ascii_mode_next = (cfg_valid && cfg_ready) ? cfg_data : ascii_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascii_mode_reg <= 1'b0;
        end else begin
            ascii_mode_reg <= ascii_mode_next;
        end
    end

    lcsp_front #(
        .CODE_WIDTH(CODE_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lcsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    lcsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ascii_mode (ascii_mode_reg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `LCSP_ASSERT_IMP(a_accept_pushes, aclk, aresetn, s_tvalid && s_tready, push, "accepted word not queued")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the LSB-first code/symbol packer.
`timescale 1ns / 1ps

module tb;
    import lcsp_pkg::*;

    localparam int CODE_W  = 16;
    localparam int DRAIN   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    cmd_t      cmd_backlog[$];
    cmd_t      cmd_on_bus;
    out_word_t expected_words[$];
    out_word_t got_exp;
    int        n_queued = 0;
    int        n_accepted = 0;
    int        fail_cnt = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        hold_left = 0;
    bit        idle_on = 1'b1;

    // predictor state
    logic [7:0] pend_bits = '0;
    int         pend_cnt = 0;
    bit         ascii_mode = 1'b0;
    logic [7:0] word_buf [0:25];
    int         word_n;

    lsb_first_code_symbol_packer #(.CODE_WIDTH(CODE_W)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // code[15:0] code_len[20:16] symbol[28:21]
        .s_tuser   (s_tuser),   // kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_byte[7:0]
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function void emit_word(logic [7:0] w);
        word_buf[word_n] = w;
        word_n++;
    endfunction

    function void push_bit(logic b);
        pend_bits[pend_cnt] = b;
        pend_cnt++;
        if (pend_cnt == 8) begin
            emit_word(pend_bits);
            pend_bits = '0;
            pend_cnt = 0;
        end
    endfunction

    function void put_field(logic [15:0] value, int len);
        int i;
        if (ascii_mode) begin
            emit_word(CHAR_SPACE);
            for (i = 0; i < len; i++)
                emit_word(value[i] ? CHAR_ONE : CHAR_ZERO);
        end else begin
            for (i = 0; i < len; i++)
                push_bit(value[i]);
        end
    endfunction

    function void pack_item(cmd_t it);
        int eff_len;
        int i;
        word_n = 0;
        if (it.kind == KIND_PAIR) begin
            eff_len = int'(it.len);
            if (eff_len > CODE_W)
                eff_len = CODE_W;
            if (eff_len > CODE_BITS)
                eff_len = CODE_BITS;
            put_field(it.code, eff_len);
            put_field({8'h00, it.symbol}, SYM_BITS);
        end else if (!ascii_mode && pend_cnt != 0) begin
            emit_word(pend_bits);
            pend_bits = '0;
            pend_cnt = 0;
        end
        for (i = 0; i < word_n; i++)
            expected_words.push_back({word_buf[i], i == word_n - 1});
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function cmd_t random_cmd();
        cmd_t c;
        int   r;
        c.kind   = ($urandom_range(0, 99) < 15) ? KIND_FLUSH : KIND_PAIR;
        c.code   = 16'($urandom);
        c.symbol = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)
            c.len = 5'($urandom_range(1, 16));
        else if (r < 78)
            c.len = 5'd0;
        else if (r < 88)
            c.len = 5'($urandom_range(17, 31));
        else
            c.len = (r < 94) ? 5'd1 : 5'd16;
        return c;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_item(cmd_on_bus);
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cmd_on_bus.symbol, cmd_on_bus.len, cmd_on_bus.code};
                    s_tuser  <= cmd_on_bus.kind;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word out_byte=%0h last=%0b", m_tdata, m_tlast);
                    fail_cnt++;
                end else begin
                    got_exp = expected_words.pop_front();
                    if (m_tdata !== got_exp.data) begin
                        $error("out_byte expected %0h actual %0h", got_exp.data, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== got_exp.last) begin
                        $error("last expected %0b actual %0b", got_exp.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task stage_cmd(kind_t kind, logic [15:0] code, logic [4:0] len, logic [7:0] symbol);
        cmd_t c;
        c.kind   = kind;
        c.code   = code;
        c.len    = len;
        c.symbol = symbol;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    task wait_drained();
        while (n_accepted != n_queued || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task write_mode(bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ascii_mode = v;
    endtask

    task run_random(bit mode, int count, bit idle, int hold);
        int i;
        write_mode(mode);
        idle_on = idle;
        hold_left = hold;
        for (i = 0; i < count; i++) begin
            cmd_backlog.push_back(random_cmd());
            n_queued++;
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // packed mode: lengths, extremes, flush with and without pending bits
        write_mode(1'b0);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        stage_cmd(KIND_PAIR,  16'h00FF, 5'd8,  8'h00);
        stage_cmd(KIND_FLUSH, 16'hFFFF, 5'd31, 8'hFF);
        stage_cmd(KIND_PAIR,  16'hFFFF, 5'd16, 8'hFF);
        stage_cmd(KIND_PAIR,  16'h0001, 5'd1,  8'hA5);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        stage_cmd(KIND_PAIR,  16'hFFFF, 5'd0,  8'h3C);
        stage_cmd(KIND_PAIR,  16'h8001, 5'd31, 8'h5A);
        stage_cmd(KIND_PAIR,  16'h1234, 5'd17, 8'h00);
        stage_cmd(KIND_PAIR,  16'h0015, 5'd5,  8'h81);
        stage_cmd(KIND_PAIR,  16'h0000, 5'd16, 8'h00);
        stage_cmd(KIND_FLUSH, 16'hABCD, 5'd9,  8'h77);
        stage_cmd(KIND_PAIR,  16'h0005, 5'd3,  8'hC3);
        wait_drained();

        // text mode keeps the pending bits for later
        write_mode(1'b1);
        stage_cmd(KIND_PAIR,  16'hFFFF, 5'd0,  8'h96);
        stage_cmd(KIND_PAIR,  16'hFFFF, 5'd16, 8'hFF);
        stage_cmd(KIND_PAIR,  16'h0000, 5'd31, 8'h00);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        stage_cmd(KIND_PAIR,  16'h0001, 5'd1,  8'h01);
        wait_drained();

        write_mode(1'b0);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        stage_cmd(KIND_FLUSH, 16'h0000, 5'd0,  8'h00);
        wait_drained();

        run_random(1'b0, 60, 1'b1, 0);
        run_random(1'b1, 40, 1'b1, 0);
        run_random(1'b0, 70, 1'b0, 0);
        run_random(1'b0, 60, 1'b1, 400);
        run_random(1'b1, 40, 1'b1, 0);
        run_random(1'b0, 60, 1'b1, 0);
        run_random(1'b1, 40, 1'b0, 0);
        run_random(1'b0, 60, 1'b1, 0);

        if (fail_cnt == 0) begin
            $display("lsb_first_code_symbol_packer verification clean");
        end else begin
            $display("lsb_first_code_symbol_packer verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("lsb_first_code_symbol_packer verification failed");
        $finish;
    end

endmodule
